// ----- src/clns_pkg.sv -----
package clns_pkg;

	localparam int CmdW       = 3;
	localparam int ByteW      = 8;
	localparam int NibW       = 4;
	localparam int WaitBeforeW = 8;
	localparam int WaitAfterW = 5;
	localparam int LongW      = 4;
	localparam int PhaseW     = 4;
	localparam int CfgIndexW  = 3;
	localparam int CfgDataW   = 8;
	localparam int StepW      = 4;

	typedef enum logic [CmdW-1:0] {
		CMD_INIT       = 3'd0,
		CMD_WRITE_INSTR = 3'd1,
		CMD_WRITE_CHAR = 3'd2,
		CMD_SET_CURSOR = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	typedef enum logic [CfgIndexW-1:0] {
		REG_POWER_UP   = 3'd0,
		REG_WAKE_FIRST = 3'd1,
		REG_LONG_INSTR = 3'd2,
		REG_ENABLE_PHASE = 3'd3
	} reg_index_t;

	localparam logic [ByteW-1:0] INSTR_FUNCTION_SET = 8'h28;
	localparam logic [ByteW-1:0] INSTR_DISPLAY_ON   = 8'h0C;
	localparam logic [ByteW-1:0] INSTR_ENTRY_MODE   = 8'h06;
	localparam logic [ByteW-1:0] INSTR_CLEAR        = 8'h01;
	localparam logic [ByteW-1:0] INSTR_HOME         = 8'h02;
	localparam logic [ByteW-1:0] SECOND_LINE_BASE   = 8'h40;
	localparam logic [ByteW-1:0] SET_ADDRESS_FLAG   = 8'h80;
	localparam logic [NibW-1:0]  WAKE_NIBBLE        = 4'h3;
	localparam logic [NibW-1:0]  FOUR_BIT_NIBBLE    = 4'h2;

	localparam logic [StepW-1:0] INIT_LAST_STEP = 4'd11;
	localparam logic [StepW-1:0] BYTE_LAST_STEP = 4'd1;

	localparam logic [7:0] POWER_UP_RESET   = 8'd50;
	localparam logic [4:0] WAKE_FIRST_RESET = 5'd5;
	localparam logic [3:0] LONG_INSTR_RESET = 4'd2;
	localparam logic [3:0] ENABLE_PHASE_RESET = 4'd1;

	typedef struct packed {
		logic [CmdW-1:0]  command;
		logic [ByteW-1:0] data_byte;
		logic [1:0]       cursor_row;
		logic [5:0]       cursor_column;
	} in_word_t;

	typedef struct packed {
		logic                   register_select;
		logic [NibW-1:0]        data_nibble;
		logic [WaitBeforeW-1:0] wait_before_ms;
		logic [WaitAfterW-1:0]  wait_after_ms;
		logic                   last;
	} out_word_t;

	// nibble sent at a given init step: wake sequence, then four instruction bytes
	function automatic logic [NibW-1:0] init_nibble(input logic [StepW-1:0] step);
		logic [ByteW-1:0] b;
		case (step[StepW-1:1])
			3'd2:    b = INSTR_FUNCTION_SET;
			3'd3:    b = INSTR_DISPLAY_ON;
			3'd4:    b = INSTR_ENTRY_MODE;
			default: b = INSTR_CLEAR;
		endcase
		if (step == 4'd3)
			init_nibble = FOUR_BIT_NIBBLE;
		else if (step < 4'd3)
			init_nibble = WAKE_NIBBLE;
		else if (step[0])
			init_nibble = b[NibW-1:0];
		else
			init_nibble = b[ByteW-1:NibW];
	endfunction

endpackage

// ----- src/char_lcd_nibble_sequencer_unit.sv -----
// channel | direction | handshake       | word
// in      | input     | in_valid/in_stall   | in_word_t: command, byte, row, column
// out     | output    | out_valid/out_stall | out_word_t: one enable strobe
// cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// A request loads a step counter; one strobe word is built per cycle by the
// shared nibble/wait select while the output does not stall. The input is
// stalled from the accept edge until the last word is loaded: init gives
// twelve words and the other commands two, and an output stall prolongs it.
// Unknown commands are accepted while idle and give no word.
// Reset (arst_n low) clears control and returns config registers to their defaults.
module char_lcd_nibble_sequencer_unit
	import clns_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_word,
	input  logic                 cfg_write,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t               state_q;
	logic [StepW-1:0]     step_q;
	logic                 init_q;
	logic                 rs_q;
	logic [ByteW-1:0]     byte_q;
	logic [WaitAfterW-1:0] low_after_q;
	logic                 out_valid_q;
	out_word_t            out_q;

	logic [7:0]        power_up_q;
	logic [4:0]        wake_first_q;
	logic [LongW-1:0]  long_instr_q;
	logic [PhaseW-1:0] enable_phase_q;

	logic                  in_accept;
	logic                  emit;
	logic                  known_cmd;
	logic [ByteW-1:0]      req_byte;
	logic [ByteW-1:0]      cursor_addr;
	logic [WaitAfterW-1:0] req_low_after;
	logic [WaitAfterW-1:0] long_wait;
	logic [WaitAfterW-1:0] double_wait;
	out_word_t             strobe;
	logic                  strobe_last;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign emit      = (state_q == ST_RUN) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	assign long_wait   = {1'b0, long_instr_q};
	assign double_wait = {long_instr_q, 1'b0};
	assign cursor_addr = SET_ADDRESS_FLAG |
		(((in_word.cursor_row == 2'd1) ? SECOND_LINE_BASE : 8'h00) +
		{2'b00, in_word.cursor_column});

	always_comb begin
		known_cmd     = 1'b1;
		req_byte      = in_word.data_byte;
		req_low_after = '0;
		case (in_word.command)
			CMD_INIT: begin
				req_byte = INSTR_CLEAR;
			end
			CMD_WRITE_INSTR: begin
				if (in_word.data_byte == INSTR_CLEAR || in_word.data_byte == INSTR_HOME)
					req_low_after = long_wait;
			end
			CMD_WRITE_CHAR: begin
			end
			CMD_SET_CURSOR: begin
				req_byte = cursor_addr;
			end
			CMD_CLEAR: begin
				req_byte      = INSTR_CLEAR;
				req_low_after = double_wait;
			end
			default: begin
				known_cmd = 1'b0;
			end
		endcase
	end

	// shared strobe select
	always_comb begin
		strobe_last = init_q ? (step_q == INIT_LAST_STEP) : (step_q == BYTE_LAST_STEP);
		strobe.register_select = rs_q;
		strobe.wait_before_ms  = '0;
		strobe.wait_after_ms   = '0;
		strobe.last            = strobe_last;
		if (init_q) begin
			strobe.data_nibble = init_nibble(step_q);
			if (step_q == '0) begin
				strobe.wait_before_ms = power_up_q;
				strobe.wait_after_ms  = wake_first_q;
			end else if (step_q < 4'd4) begin
				strobe.wait_after_ms = 5'd1;
			end else if (strobe_last) begin
				strobe.wait_after_ms = double_wait;
			end
		end else begin
			strobe.data_nibble = step_q[0] ? byte_q[NibW-1:0] : byte_q[ByteW-1:NibW];
			if (step_q[0])
				strobe.wait_after_ms = low_after_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_accept && known_cmd) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						init_q  <= (in_word.command == CMD_INIT);
					end
				end
				ST_RUN: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						step_q      <= step_q + 4'd1;
						if (strobe_last)
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rs_q        <= (in_word.command == CMD_WRITE_CHAR);
			byte_q      <= req_byte;
			low_after_q <= req_low_after;
		end
		if (emit)
			out_q <= strobe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_up_q     <= POWER_UP_RESET;
			wake_first_q   <= WAKE_FIRST_RESET;
			long_instr_q   <= LONG_INSTR_RESET;
			enable_phase_q <= ENABLE_PHASE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_POWER_UP:     power_up_q     <= cfg_data;
				REG_WAKE_FIRST:   wake_first_q   <= cfg_data[4:0];
				REG_LONG_INSTR:   long_instr_q   <= cfg_data[LongW-1:0];
				REG_ENABLE_PHASE: enable_phase_q <= cfg_data[PhaseW-1:0];
				default: begin
				end
			endcase
		end
	end

	// enable phase is stored but not used in this unit; it does not shape the words
	logic phase_unused;
	assign phase_unused = ^enable_phase_q;

endmodule
